// File: rtl/core/ftb_pkg.sv
`default_nettype none

package ftb_pkg;

	// Packed field widths on the ports
	localparam int POS_W = 48;
	localparam int UV_W  = 32;

	// Normalized magnitudes sit in [2^29, 2^30)
	localparam int MAG_W  = 30;
	// Square root of a sum of three squared magnitudes fits in 31 bits
	localparam int ROOT_W = MAG_W + 1;
	// Sum of three 60-bit squares
	localparam int SQ_W   = 2 * MAG_W + 2;

endpackage

`default_nettype wire

// File: rtl/core/ftb_unitize.sv
`default_nettype none

// Scales a signed integer vector to unit length, Q1.UNIT_FRAC per component.
// Stages: abs, leading one, shift, squares, sum, one root bit per stage,
// dividend prep, one quotient bit per stage, sign.
module ftb_unitize #(
	parameter int VW        = 35,
	parameter int UNIT_FRAC = 14
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [VW-1:0]        vec  [3],
	output logic signed [UNIT_FRAC+1:0] unit [3],
	output logic                        zero
);

	localparam int MW = ftb_pkg::MAG_W;
	localparam int RW = ftb_pkg::ROOT_W;
	localparam int SW = ftb_pkg::SQ_W;
	localparam int TW = SW + 1;
	localparam int UW = UNIT_FRAC + 2;
	localparam int QW = UNIT_FRAC + 1;
	localparam int DW = RW + UNIT_FRAC;
	localparam int LW = $clog2(VW);
	localparam int AW = LW + 1;
	localparam int XW = VW + MW;

	// Stage A: magnitudes and signs
	logic [VW-1:0] mag_a [3];
	logic          sgn_a [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sgn_a[i] <= vec[i][VW-1];
				mag_a[i] <= vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
			end
		end
	end

	// Stage B: position of the leading one over all three magnitudes
	logic [VW-1:0] orv;
	logic [LW-1:0] lead_d;
	logic [LW-1:0] lead_b;
	logic          zero_b;
	logic [VW-1:0] mag_b [3];
	logic          sgn_b [3];

	assign orv = mag_a[0] | mag_a[1] | mag_a[2];

	always_comb begin
		lead_d = '0;
		for (int k = 0; k < VW; k++) begin
			if (orv[k]) begin
				lead_d = LW'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lead_b <= lead_d;
			zero_b <= (orv == '0);
			mag_b  <= mag_a;
			sgn_b  <= sgn_a;
		end
	end

	// Stage C: shift so the leading one lands on bit MW-1
	logic [AW-1:0] amt;
	logic [XW-1:0] wide [3];
	logic [MW-1:0] mag_c [3];
	logic          sgn_c [3];
	logic          zero_c;

	assign amt = AW'(lead_b) + AW'(1);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide[i] = {mag_b[i], {MW{1'b0}}} >> amt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_c[i] <= wide[i][MW-1:0];
			end
			sgn_c  <= sgn_b;
			zero_c <= zero_b;
		end
	end

	// Stage D: squares
	logic [2*MW-1:0] sq_d  [3];
	logic [MW-1:0]   mag_d [3];
	logic            sgn_d [3];
	logic            zero_d;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_d[i] <= mag_c[i] * mag_c[i];
			end
			mag_d  <= mag_c;
			sgn_d  <= sgn_c;
			zero_d <= zero_c;
		end
	end

	// Stage E: sum of squares, start of the root pipeline
	logic [SW-1:0] rem_r  [RW+1];
	logic [RW-1:0] root_r [RW+1];
	logic [MW-1:0] mag_r  [RW+1][3];
	logic          sgn_r  [RW+1][3];
	logic          zero_r [RW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_r[0]  <= SW'(sq_d[0]) + SW'(sq_d[1]) + SW'(sq_d[2]);
			root_r[0] <= '0;
			mag_r[0]  <= mag_d;
			sgn_r[0]  <= sgn_d;
			zero_r[0] <= zero_d;
		end
	end

	// Integer square root, one result bit per stage, MSB first
	for (genvar k = 0; k < RW; k++) begin : g_root
		localparam int BIT = RW - 1 - k;
		logic [TW-1:0] trial;
		logic          ge;

		assign trial = (TW'(root_r[k]) << (BIT + 1)) + (TW'(1) << (2 * BIT));
		assign ge    = {1'b0, rem_r[k]} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_r[k+1]  <= ge ? SW'({1'b0, rem_r[k]} - trial) : rem_r[k];
				root_r[k+1] <= root_r[k] | (RW'(ge) << BIT);
				mag_r[k+1]  <= mag_r[k];
				sgn_r[k+1]  <= sgn_r[k];
				zero_r[k+1] <= zero_r[k];
			end
		end
	end

	// Prep: rounded dividend mag * 2^F + r/2
	logic [DW-1:0] drem [QW+1][3];
	logic [QW-1:0] quo  [QW+1][3];
	logic [RW-1:0] dvs  [QW+1];
	logic          sgn_q  [QW+1][3];
	logic          zero_q [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				drem[0][i] <= (DW'(mag_r[RW][i]) << UNIT_FRAC) + DW'(root_r[RW] >> 1);
				quo[0][i]  <= '0;
			end
			dvs[0]    <= root_r[RW];
			sgn_q[0]  <= sgn_r[RW];
			zero_q[0] <= zero_r[RW];
		end
	end

	// Restoring division, one quotient bit per stage
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int BIT = QW - 1 - j;
		logic [DW-1:0] dsh;
		logic          ge [3];

		assign dsh = DW'(dvs[j]) << BIT;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i] = drem[j][i] >= dsh;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					drem[j+1][i] <= ge[i] ? drem[j][i] - dsh : drem[j][i];
					quo[j+1][i]  <= quo[j][i] | (QW'(ge[i]) << BIT);
				end
				dvs[j+1]    <= dvs[j];
				sgn_q[j+1]  <= sgn_q[j];
				zero_q[j+1] <= zero_q[j];
			end
		end
	end

	// Final stage: apply sign
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				unit[i] <= sgn_q[QW][i] ? -UW'(quo[QW][i]) : UW'(quo[QW][i]);
			end
			zero <= zero_q[QW];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/face_tangent_basis.sv
// Per-face tangent basis for one triangle.
// Input channel (in_valid/in_ready): three vertex positions pos_a..pos_c and
// three texture coordinates uv_a..uv_c, COORD_WIDTH-bit signed components
// packed from the low end. Output channel (out_valid/out_ready): unit tangent
// and binormal, Q1.UNIT_FRAC components packed in 48 bits, and degenerate,
// set (with zero vectors) when the normal, tangent or binormal has no length.
// Throughput: one triangle per cycle while in_ready is high. The pipeline
// depth is set by the square root (one bit per stage, 31 stages) and the
// divider (one quotient bit per stage) that normalize each vector.
// The whole pipeline advances together. An output register plus one skid
// entry sit behind it: while the receiver stalls, the pipeline keeps taking
// triangles until the skid entry fills, then in_ready drops and every stage
// holds its contents. Reset (arst_n low) clears all valid bits, including
// those of the output and skid registers; data registers are not reset.
`default_nettype none

module face_tangent_basis #(
	parameter int COORD_WIDTH = 16,
	parameter int UNIT_FRAC   = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ftb_pkg::POS_W-1:0]  pos_a,
	input  logic [ftb_pkg::POS_W-1:0]  pos_b,
	input  logic [ftb_pkg::POS_W-1:0]  pos_c,
	input  logic [ftb_pkg::UV_W-1:0]   uv_a,
	input  logic [ftb_pkg::UV_W-1:0]   uv_b,
	input  logic [ftb_pkg::UV_W-1:0]   uv_c,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ftb_pkg::POS_W-1:0]  tangent_out,
	output logic [ftb_pkg::POS_W-1:0]  binormal_out,
	output logic                       degenerate
);

	localparam int CW       = COORD_WIDTH;
	localparam int EW       = CW + 1;
	localparam int PW       = 2 * EW;
	localparam int VW       = PW + 1;
	localparam int UW       = UNIT_FRAC + 2;
	localparam int XPW      = 2 * UW;
	localparam int XVW      = XPW + 1;
	localparam int DPW      = XVW + UW;
	localparam int DSW      = DPW + 2;
	localparam int UNIT_LAT = ftb_pkg::ROOT_W + UNIT_FRAC + 8;
	localparam int NSTG     = UNIT_LAT + 7;
	localparam int OW       = ftb_pkg::POS_W;
	localparam int PXW      = OW + 3 * CW;
	localparam int UXW      = ftb_pkg::UV_W + 2 * CW;

	logic en;
	logic sv_q;
	logic ov_q;

	assign en       = !sv_q;
	assign in_ready = en;

	// Valid bits, one per pipeline stage
	logic vld_s [NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSTG; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < NSTG; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Component unpacking; bits beyond the port read as zero
	logic [PXW-1:0] pa_x, pb_x, pc_x;
	logic [UXW-1:0] ua_x, ub_x, uc_x;
	logic [CW-1:0]  ca [3], cb [3], cc [3];
	logic [CW-1:0]  ta [2], tb [2], tc [2];

	assign pa_x = {{(3*CW){1'b0}}, pos_a};
	assign pb_x = {{(3*CW){1'b0}}, pos_b};
	assign pc_x = {{(3*CW){1'b0}}, pos_c};
	assign ua_x = {{(2*CW){1'b0}}, uv_a};
	assign ub_x = {{(2*CW){1'b0}}, uv_b};
	assign uc_x = {{(2*CW){1'b0}}, uv_c};

	for (genvar i = 0; i < 3; i++) begin : g_pos
		assign ca[i] = pa_x[i*CW +: CW];
		assign cb[i] = pb_x[i*CW +: CW];
		assign cc[i] = pc_x[i*CW +: CW];
	end

	for (genvar i = 0; i < 2; i++) begin : g_uv
		assign ta[i] = ua_x[i*CW +: CW];
		assign tb[i] = ub_x[i*CW +: CW];
		assign tc[i] = uc_x[i*CW +: CW];
	end

	// Stage 1: edges and texture deltas
	logic signed [EW-1:0] e0_s1 [3], e1_s1 [3];
	logic signed [EW-1:0] du0_s1, du1_s1, dv0_s1, dv1_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e0_s1[i] <= $signed({ca[i][CW-1], ca[i]}) - $signed({cb[i][CW-1], cb[i]});
				e1_s1[i] <= $signed({cc[i][CW-1], cc[i]}) - $signed({ca[i][CW-1], ca[i]});
			end
			du0_s1 <= $signed({ta[0][CW-1], ta[0]}) - $signed({tb[0][CW-1], tb[0]});
			du1_s1 <= $signed({tc[0][CW-1], tc[0]}) - $signed({ta[0][CW-1], ta[0]});
			dv0_s1 <= $signed({ta[1][CW-1], ta[1]}) - $signed({tb[1][CW-1], tb[1]});
			dv1_s1 <= $signed({tc[1][CW-1], tc[1]}) - $signed({ta[1][CW-1], ta[1]});
		end
	end

	// Stage 2: products for normal (e1 x e0), tangent and binormal
	logic signed [PW-1:0] np_s2 [3][2], tp_s2 [3][2], bp_s2 [3][2];

	always_ff @(posedge clk) begin
		if (en) begin
			np_s2[0][0] <= e1_s1[1] * e0_s1[2];
			np_s2[0][1] <= e1_s1[2] * e0_s1[1];
			np_s2[1][0] <= e1_s1[2] * e0_s1[0];
			np_s2[1][1] <= e1_s1[0] * e0_s1[2];
			np_s2[2][0] <= e1_s1[0] * e0_s1[1];
			np_s2[2][1] <= e1_s1[1] * e0_s1[0];
			for (int i = 0; i < 3; i++) begin
				tp_s2[i][0] <= e0_s1[i] * dv1_s1;
				tp_s2[i][1] <= e1_s1[i] * dv0_s1;
				bp_s2[i][0] <= e0_s1[i] * du1_s1;
				bp_s2[i][1] <= e1_s1[i] * du0_s1;
			end
		end
	end

	// Stage 3: raw vectors
	logic signed [VW-1:0] n_s3 [3], t_s3 [3], b_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s3[i] <= VW'(np_s2[i][0]) - VW'(np_s2[i][1]);
				t_s3[i] <= VW'(tp_s2[i][0]) - VW'(tp_s2[i][1]);
				b_s3[i] <= VW'(bp_s2[i][0]) - VW'(bp_s2[i][1]);
			end
		end
	end

	// Normalization of all three vectors in lockstep
	logic signed [UW-1:0] nu [3], tu [3], bu [3];
	logic                 zn, zt, zb;

	ftb_unitize #(.VW(VW), .UNIT_FRAC(UNIT_FRAC)) u_norm_n (
		.clk(clk), .en(en), .vec(n_s3), .unit(nu), .zero(zn)
	);

	ftb_unitize #(.VW(VW), .UNIT_FRAC(UNIT_FRAC)) u_norm_t (
		.clk(clk), .en(en), .vec(t_s3), .unit(tu), .zero(zt)
	);

	ftb_unitize #(.VW(VW), .UNIT_FRAC(UNIT_FRAC)) u_norm_b (
		.clk(clk), .en(en), .vec(b_s3), .unit(bu), .zero(zb)
	);

	// Stages 4..7 follow the normalizer stages
	// Stage 4: products of t x b
	logic signed [XPW-1:0] xp_s4 [3][2];
	logic signed [UW-1:0]  tu_s4 [3], bu_s4 [3], nu_s4 [3];
	logic                  deg_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s4[0][0] <= tu[1] * bu[2];
			xp_s4[0][1] <= tu[2] * bu[1];
			xp_s4[1][0] <= tu[2] * bu[0];
			xp_s4[1][1] <= tu[0] * bu[2];
			xp_s4[2][0] <= tu[0] * bu[1];
			xp_s4[2][1] <= tu[1] * bu[0];
			tu_s4  <= tu;
			bu_s4  <= bu;
			nu_s4  <= nu;
			deg_s4 <= zn | zt | zb;
		end
	end

	// Stage 5: t x b
	logic signed [XVW-1:0] xc_s5 [3];
	logic signed [UW-1:0]  tu_s5 [3], bu_s5 [3], nu_s5 [3];
	logic                  deg_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				xc_s5[i] <= XVW'(xp_s4[i][0]) - XVW'(xp_s4[i][1]);
			end
			tu_s5  <= tu_s4;
			bu_s5  <= bu_s4;
			nu_s5  <= nu_s4;
			deg_s5 <= deg_s4;
		end
	end

	// Stage 6: dot product terms against the normal
	logic signed [DPW-1:0] dp_s6 [3];
	logic signed [UW-1:0]  tu_s6 [3], bu_s6 [3];
	logic                  deg_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dp_s6[i] <= xc_s5[i] * nu_s5[i];
			end
			tu_s6  <= tu_s5;
			bu_s6  <= bu_s5;
			deg_s6 <= deg_s5;
		end
	end

	// Stage 7: orientation sign
	logic signed [DSW-1:0] dsum;
	logic                  neg_s7;
	logic signed [UW-1:0]  tu_s7 [3], bu_s7 [3];
	logic                  deg_s7;

	assign dsum = DSW'(dp_s6[0]) + DSW'(dp_s6[1]) + DSW'(dp_s6[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s7 <= dsum[DSW-1];
			tu_s7  <= tu_s6;
			bu_s7  <= bu_s6;
			deg_s7 <= deg_s6;
		end
	end

	// Final flip, zeroing and packing
	logic [UW-1:0]      tf [3], bf [3];
	logic [3*UW+OW-1:0] tpk, bpk;
	logic [OW-1:0]      tan_d, bin_d;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tf[i] = deg_s7 ? '0 : (neg_s7 ? UW'(-tu_s7[i]) : UW'(tu_s7[i]));
			bf[i] = deg_s7 ? '0 : UW'(bu_s7[i]);
		end
	end

	assign tpk   = {{OW{1'b0}}, tf[2], tf[1], tf[0]};
	assign bpk   = {{OW{1'b0}}, bf[2], bf[1], bf[0]};
	assign tan_d = tpk[OW-1:0];
	assign bin_d = bpk[OW-1:0];

	// Output register and skid entry control
	logic take;

	assign take = out_ready || !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (take) begin
			if (sv_q) begin
				ov_q <= 1'b1;
				sv_q <= 1'b0;
			end else begin
				ov_q <= vld_s[NSTG-1];
			end
		end else if (!sv_q && vld_s[NSTG-1]) begin
			sv_q <= 1'b1;
		end
	end

	// Output and skid payload
	logic [OW-1:0] tan_q, bin_q, tan_skid_q, bin_skid_q;
	logic          deg_q, deg_skid_q;

	always_ff @(posedge clk) begin
		if (take) begin
			if (sv_q) begin
				tan_q <= tan_skid_q;
				bin_q <= bin_skid_q;
				deg_q <= deg_skid_q;
			end else begin
				tan_q <= tan_d;
				bin_q <= bin_d;
				deg_q <= deg_s7;
			end
		end else if (!sv_q) begin
			tan_skid_q <= tan_d;
			bin_skid_q <= bin_d;
			deg_skid_q <= deg_s7;
		end
	end

	assign out_valid    = ov_q;
	assign tangent_out  = tan_q;
	assign binormal_out = bin_q;
	assign degenerate   = deg_q;

endmodule

`default_nettype wire

// File: rtl/core/ftb_checker.sv
`default_nettype none

module ftb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] tangent_out,
	input logic [47:0] binormal_out,
	input logic        degenerate
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before transfer");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(tangent_out) && $stable(binormal_out)
			&& $stable(degenerate))
		else $error("output payload changed while stalled");

	// Degenerate triangles report zero vectors
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tangent_out == '0 && binormal_out == '0)
		else $error("degenerate result with nonzero vectors");

	// Input back-pressure only while a result is waiting at the output
	a_busy_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no result held");

endmodule

bind face_tangent_basis ftb_checker u_ftb_checker (.*);

`default_nettype wire

// File: bench/tb_face_tangent_basis.sv
`timescale 1ns / 100ps

// Expected tangent basis per triangle, checked in transfer order
class basis_scoreboard;
	typedef struct packed {
		logic [47:0] tangent;
		logic [47:0] binormal;
		logic        degen;
	} basis_t;

	basis_t pending[$];
	int     mismatches;
	int     checked;

	function automatic longint coord(logic [47:0] packed_v, int idx);
		logic signed [15:0] c;
		c = packed_v[idx*16 +: 16];
		return longint'(c);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= r + bitv) begin
				n -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	// Scale to [2^29, 2^30), then divide by rounded-down root of sum of squares
	function automatic bit unit_vec(input longint v[3], output longint u[3]);
		longint unsigned mag[3], m, s, r, q;
		m = 0;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? -v[i] : v[i];
			if (mag[i] > m)
				m = mag[i];
		end
		if (m == 0)
			return 0;
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++)
				mag[i] >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++)
				mag[i] <<= 1;
		end
		for (int i = 0; i < 3; i++)
			s += mag[i] * mag[i];
		r = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << 14) + r / 2) / r;
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic void cross_prod(input longint p[3], input longint q[3],
			output longint o[3]);
		o[0] = p[1] * q[2] - p[2] * q[1];
		o[1] = p[2] * q[0] - p[0] * q[2];
		o[2] = p[0] * q[1] - p[1] * q[0];
	endfunction

	function automatic logic [47:0] pack_unit(longint v[3]);
		logic [47:0] r;
		for (int i = 0; i < 3; i++)
			r[i*16 +: 16] = v[i][15:0];
		return r;
	endfunction

	function void note_triangle(logic [47:0] pa, logic [47:0] pb, logic [47:0] pc,
			logic [31:0] ta, logic [31:0] tb, logic [31:0] tc);
		longint e0[3], e1[3], n[3], t[3], b[3], nu[3], tu[3], bu[3], tbx[3];
		longint du0, du1, dv0, dv1, dotv;
		bit ok;
		basis_t exp_basis;
		for (int i = 0; i < 3; i++) begin
			e0[i] = coord(pa, i) - coord(pb, i);
			e1[i] = coord(pc, i) - coord(pa, i);
		end
		du0 = coord(ta, 0) - coord(tb, 0);
		du1 = coord(tc, 0) - coord(ta, 0);
		dv0 = coord(ta, 1) - coord(tb, 1);
		dv1 = coord(tc, 1) - coord(ta, 1);
		cross_prod(e1, e0, n);
		for (int i = 0; i < 3; i++) begin
			t[i] = e0[i] * dv1 - e1[i] * dv0;
			b[i] = e0[i] * du1 - e1[i] * du0;
		end
		ok = unit_vec(n, nu);
		ok = unit_vec(t, tu) && ok;
		ok = unit_vec(b, bu) && ok;
		if (!ok) begin
			exp_basis = '{48'd0, 48'd0, 1'b1};
		end else begin
			// unit components are tiny, so the dot product fits in 64 bits
			cross_prod(tu, bu, tbx);
			dotv = tbx[0] * nu[0] + tbx[1] * nu[1] + tbx[2] * nu[2];
			if (dotv < 0)
				for (int i = 0; i < 3; i++)
					tu[i] = -tu[i];
			exp_basis = '{pack_unit(tu), pack_unit(bu), 1'b0};
		end
		pending.insert(pending.size(), exp_basis);
	endfunction

	function void check_basis(logic [47:0] tan, logic [47:0] bin, logic degen);
		basis_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected output transfer t=%h b=%h d=%b", tan, bin, degen);
			return;
		end
		e = pending.pop_front();
		checked++;
		if (tan !== e.tangent || bin !== e.binormal || degen !== e.degen) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: result %0d exp t=%h b=%h d=%b got t=%h b=%h d=%b",
					checked, e.tangent, e.binormal, e.degen, tan, bin, degen);
		end
	endfunction
endclass

module tb_face_tangent_basis;

	localparam int LATENCY = 61;
	localparam int WATCHDOG = 2000;
	localparam int N_RANDOM = 1500;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [ftb_pkg::POS_W-1:0] pos_a = 0, pos_b = 0, pos_c = 0;
	logic [ftb_pkg::UV_W-1:0] uv_a = 0, uv_b = 0, uv_c = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [ftb_pkg::POS_W-1:0] tangent_out, binormal_out;
	logic degenerate;

	basis_scoreboard sb = new();
	int idle_cycles;
	int sent;
	int degen_seen;

	face_tangent_basis uut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Accepted transfers on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_triangle(pos_a, pos_b, pos_c, uv_a, uv_b, uv_c);
			end
			if (out_valid && out_ready) begin
				sb.check_basis(tangent_out, binormal_out, degenerate);
				if (degenerate)
					degen_seen++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Receiver: random stall before each result, sometimes none
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 10);
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	task automatic send_triangle(logic [47:0] pa, logic [47:0] pb, logic [47:0] pc,
			logic [31:0] ta, logic [31:0] tb, logic [31:0] tc, int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		pos_a <= pa; pos_b <= pb; pos_c <= pc;
		uv_a <= ta; uv_b <= tb; uv_c <= tc;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	function automatic logic [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 31)) - 16'd16;
			2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'($urandom_range(0, 8191)) - 16'd4096;
		endcase
	endfunction

	function automatic logic [47:0] rand_pos(int mode);
		return {rand_coord(mode), rand_coord(mode), rand_coord(mode)};
	endfunction

	function automatic logic [31:0] rand_uv(int mode);
		return {rand_coord(mode), rand_coord(mode)};
	endfunction

	initial begin
		int gap, mode;
		logic [47:0] pa;
		logic [31:0] ta;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: axis-aligned right triangle, both windings, flipped uv
		send_triangle(48'h0, 48'h0000_0000_1000, 48'h0000_1000_0000,
			32'h0, 32'h0000_1000, 32'h1000_0000, 0);
		send_triangle(48'h0, 48'h0000_1000_0000, 48'h0000_0000_1000,
			32'h0, 32'h0000_1000, 32'h1000_0000, 0);
		send_triangle(48'h0, 48'h0000_0000_1000, 48'h0000_1000_0000,
			32'h0, 32'h1000_0000, 32'h0000_1000, 1);
		// Extreme coordinates
		send_triangle(48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'h8000_7fff_8000,
			32'h7fff_7fff, 32'h8000_8000, 32'h8000_7fff, 0);
		send_triangle(48'h8000_8000_8000, 48'h7fff_0000_7fff, 48'h0000_7fff_8000,
			32'h8000_7fff, 32'h7fff_8000, 32'h8000_8000, 0);
		send_triangle(48'hffff_ffff_ffff, 48'h0000_0000_0001, 48'h0001_0000_0000,
			32'hffff_ffff, 32'h0000_0001, 32'h0001_0000, 2);
		// Degenerate: collinear points, repeated point, flat uv, zero u delta
		send_triangle(48'h0, 48'h0000_0000_1000, 48'h0000_0000_2000,
			32'h0, 32'h0000_1000, 32'h1000_0000, 0);
		send_triangle(48'h0123_0456_0789, 48'h0123_0456_0789, 48'h0000_1000_0000,
			32'h0, 32'h0000_1000, 32'h1000_0000, 0);
		send_triangle(48'h0, 48'h0000_0000_1000, 48'h0000_1000_0000,
			32'h2222_1111, 32'h2222_1111, 32'h2222_1111, 0);
		send_triangle(48'h0, 48'h0000_0000_1000, 48'h0000_1000_0000,
			32'h0, 32'h1000_0000, 32'h2000_0000, 0);
		send_triangle(48'h0, 48'h0, 48'h0, 32'h0, 32'h0, 32'h0, 3);
		// Tiny and uneven triangles
		send_triangle(48'h0, 48'h0000_0000_0001, 48'h0000_0001_0000,
			32'h0, 32'h0000_0001, 32'h0001_0000, 0);
		send_triangle(48'h0001_0000_0000, 48'h0000_7fff_0000, 48'h0000_0000_8000,
			32'h0000_0001, 32'h7fff_0000, 32'h0000_8000, 0);

		// Random: mostly well-formed, some wide or degenerate-prone
		for (int i = 0; i < N_RANDOM; i++) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if ((i / 100) % 4 == 1)
				gap = 0;
			if (i == N_RANDOM / 2) begin
				// drain everything before going on
				in_valid <= 0;
				while (sb.pending.size() != 0) @(negedge clk);
				gap = 0;
			end
			mode = $urandom_range(0, 9);
			mode = mode < 5 ? 3 : mode < 7 ? 0 : mode < 9 ? 1 : 2;
			if ($urandom_range(0, 19) == 0) begin
				// shared vertex and uv, likely degenerate
				pa = rand_pos(mode);
				ta = rand_uv(mode);
				send_triangle(pa, pa, rand_pos(mode), ta, rand_uv(mode), ta, gap);
			end else begin
				send_triangle(rand_pos(mode), rand_pos(mode), rand_pos(mode),
					rand_uv(mode), rand_uv(mode), rand_uv(mode), gap);
			end
		end
		in_valid <= 0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);

		$display("Sent %0d triangles, checked %0d results (%0d degenerate).",
			sent, sb.checked, degen_seen);
		$display("Covered extreme and degenerate triangles, random stalls on both sides.");
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
